/* hdl/mfs_pkg.sv */
// ============================================================================
// mfs_pkg
// Shared types and constants of the multilevel feedback scheduler.
// ============================================================================
package mfs_pkg;

    // Default sizing of the scheduler.
    localparam int MAX_PROCS_DEF  = 16;
    localparam int NUM_LEVELS_DEF = 5;

    // Field widths of the input and result words.
    localparam int ID_W    = 4;
    localparam int SVC_W   = 16;
    localparam int LEVEL_W = 3;

    // Input opcodes.
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_EX   = 3'b100
    } t_state;

endpackage

/* hdl/mfs_if.sv */
// ============================================================================
// mfs_if
// Valid/ready channels of the scheduler: configuration, input and result.
// ============================================================================
interface mfs_cfg_if;
    import mfs_pkg::*;

    logic valid;
    logic ready;
    logic slice_mode;

    modport source (output valid, output slice_mode, input ready);
    modport sink   (input valid, input slice_mode, output ready);
endinterface

interface mfs_in_if;
    import mfs_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [ID_W-1:0]  proc_id;
    logic [SVC_W-1:0] service_time;

    modport source (output valid, output opcode, output proc_id, output service_time,
                    input ready);
    modport sink   (input valid, input opcode, input proc_id, input service_time,
                    output ready);
endinterface

interface mfs_res_if;
    import mfs_pkg::*;

    logic               valid;
    logic               ready;
    logic               ran_valid;
    logic [ID_W-1:0]    ran_id;
    logic [LEVEL_W-1:0] ran_level;
    logic               finished;

    modport source (output valid, output ran_valid, output ran_id, output ran_level,
                    output finished, input ready);
    modport sink   (input valid, input ran_valid, input ran_id, input ran_level,
                    input finished, output ready);
endinterface

/* hdl/mfs_ram.sv */
// ============================================================================
// mfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module mfs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/multilevel_feedback_scheduler.sv */
// ============================================================================
// multilevel_feedback_scheduler
// Tick-driven multilevel feedback queue scheduler with FIFO levels in RAM.
// ============================================================================
// An arrival word with a nonzero service time writes that time into the
// remaining-time RAM and queues its id at level 0 if that level has room.
// A tick word returns one result word. It goes straight to S_EX when a
// process is already running, when the tick is idle, or when the process
// just put back is picked again from a level that was empty; it goes via
// S_RD to S_EX when a new process is picked, because the queue RAM read and
// the remaining-time RAM read, each with registered data, then follow one
// another. A tick that finds the result register still full waits there
// until the word is taken. Both RAMs start undefined and need no clearing
// pass; queue state lives in head, tail and count registers that reset clears.
module multilevel_feedback_scheduler #(
    parameter int MAX_PROCS  = mfs_pkg::MAX_PROCS_DEF,
    parameter int NUM_LEVELS = mfs_pkg::NUM_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfs_cfg_if.sink     i_cfg,
    mfs_in_if.sink      i_item,
    mfs_res_if.source   o_res
);
    import mfs_pkg::*;

    localparam int PW     = $clog2(MAX_PROCS);
    localparam int LW     = $clog2(NUM_LEVELS);
    localparam int CW     = $clog2(MAX_PROCS + 1);
    localparam int SW     = NUM_LEVELS;
    localparam int QDEPTH = NUM_LEVELS * (2 ** PW);

    // Reduces an id to its remaining-time slot.
    function automatic logic [PW-1:0] slot_of(input logic [ID_W-1:0] id);
        logic [PW-1:0] s;
        s = '0;
        for (int k = 0; k < 2 ** ID_W; k++) begin
            if (id == ID_W'(k)) begin
                s = PW'(k % MAX_PROCS);
            end
        end
        return s;
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(MAX_PROCS - 1)) ? '0 : p + PW'(1);
    endfunction

    t_state             r_state, n_state;
    logic               r_slice_mode;
    logic [PW-1:0]      r_head  [NUM_LEVELS];
    logic [PW-1:0]      n_head  [NUM_LEVELS];
    logic [PW-1:0]      r_tail  [NUM_LEVELS];
    logic [PW-1:0]      n_tail  [NUM_LEVELS];
    logic [CW-1:0]      r_count [NUM_LEVELS];
    logic [CW-1:0]      n_count [NUM_LEVELS];
    logic [ID_W-1:0]    r_cur_id, n_cur_id;
    logic [LW-1:0]      r_cur_level, n_cur_level;
    logic [SW-1:0]      r_slice, n_slice;
    logic               r_active, n_active;
    logic               r_requeue, n_requeue;
    logic               r_idle, n_idle;

    logic               r_out_valid, n_out_valid;
    logic               r_out_ran_valid, n_out_ran_valid;
    logic [ID_W-1:0]    r_out_id, n_out_id;
    logic [LEVEL_W-1:0] r_out_level, n_out_level;
    logic               r_out_finished, n_out_finished;

    // Queue RAM and remaining-time RAM ports.
    logic                 q_we;
    logic [LW+PW-1:0]     q_waddr, q_raddr;
    logic [ID_W-1:0]      q_wdata, q_rdata;
    logic                 rem_we;
    logic [PW-1:0]        rem_waddr, rem_raddr;
    logic [SVC_W-1:0]     rem_wdata, rem_rdata;

    // Requeue and pick decisions, made from the registered queue state.
    logic                 any_work;
    logic [LW-1:0]        push_lvl;
    logic                 push_en;
    logic [CW-1:0]        cnt_after [NUM_LEVELS];
    logic                 pick_found;
    logic [LW-1:0]        pick_lvl;
    logic                 fwd;

    logic [SVC_W-1:0]     rem_next;
    logic [SW-1:0]        slice_dec;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        any_work = 1'b0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (r_count[l] != '0) begin
                any_work = 1'b1;
            end
        end
        push_lvl = r_cur_level;
        if (any_work && r_cur_level != LW'(NUM_LEVELS - 1)) begin
            push_lvl = r_cur_level + LW'(1);
        end
        push_en = r_requeue && (r_count[push_lvl] != CW'(MAX_PROCS));
        for (int l = 0; l < NUM_LEVELS; l++) begin
            cnt_after[l] = r_count[l] + CW'(push_en && push_lvl == LW'(l));
        end
        pick_found = 1'b0;
        pick_lvl   = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (cnt_after[l] != '0) begin
                pick_found = 1'b1;
                pick_lvl   = LW'(l);
            end
        end
        // The word just put back into an empty level is the head of that level:
        // it is still held in r_cur_id, so the queue RAM read is skipped.
        fwd = push_en && (push_lvl == pick_lvl) && (r_count[pick_lvl] == '0);
    end

    assign rem_next  = (rem_rdata != '0) ? rem_rdata - SVC_W'(1) : '0;
    assign slice_dec = (r_slice != '0) ? r_slice - SW'(1) : r_slice;
    assign q_raddr   = {pick_lvl, r_head[pick_lvl]};
    assign rem_raddr = (r_state == S_RD) ? slot_of(q_rdata) : slot_of(r_cur_id);

    always_comb begin
        n_state         = r_state;
        n_head          = r_head;
        n_tail          = r_tail;
        n_count         = r_count;
        n_cur_id        = r_cur_id;
        n_cur_level     = r_cur_level;
        n_slice         = r_slice;
        n_active        = r_active;
        n_requeue       = r_requeue;
        n_idle          = r_idle;
        n_out_valid     = r_out_valid && !o_res.ready;
        n_out_ran_valid = r_out_ran_valid;
        n_out_id        = r_out_id;
        n_out_level     = r_out_level;
        n_out_finished  = r_out_finished;
        q_we            = 1'b0;
        q_waddr         = {push_lvl, r_tail[push_lvl]};
        q_wdata         = r_cur_id;
        rem_we          = 1'b0;
        rem_waddr       = slot_of(r_cur_id);
        rem_wdata       = rem_next;

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid && i_item.opcode == OP_ARRIVAL) begin
                    if (i_item.service_time != '0) begin
                        rem_we    = 1'b1;
                        rem_waddr = slot_of(i_item.proc_id);
                        rem_wdata = i_item.service_time;
                        if (r_count[0] != CW'(MAX_PROCS)) begin
                            q_we       = 1'b1;
                            q_waddr    = {LW'(0), r_tail[0]};
                            q_wdata    = i_item.proc_id;
                            n_tail[0]  = ptr_inc(r_tail[0]);
                            n_count[0] = r_count[0] + CW'(1);
                        end
                    end
                end else if (i_item.valid) begin
                    if (r_requeue) begin
                        n_cur_level = push_lvl;
                        n_requeue   = 1'b0;
                        if (push_en) begin
                            q_we              = 1'b1;
                            n_tail[push_lvl]  = ptr_inc(r_tail[push_lvl]);
                            n_count[push_lvl] = r_count[push_lvl] + CW'(1);
                        end
                    end
                    if (r_active) begin
                        n_idle  = 1'b0;
                        n_state = S_EX;
                    end else if (!pick_found) begin
                        n_idle  = 1'b1;
                        n_state = S_EX;
                    end else begin
                        n_head[pick_lvl]  = ptr_inc(r_head[pick_lvl]);
                        n_count[pick_lvl] = cnt_after[pick_lvl] - CW'(1);
                        n_cur_level       = pick_lvl;
                        n_slice           = r_slice_mode ? (SW'(1) << pick_lvl) : SW'(1);
                        n_active          = 1'b1;
                        n_idle            = 1'b0;
                        n_state           = fwd ? S_EX : S_RD;
                    end
                end
            end
            S_RD: begin
                n_cur_id = q_rdata;
                n_state  = S_EX;
            end
            S_EX: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_idle) begin
                        n_out_ran_valid = 1'b0;
                        n_out_id        = '0;
                        n_out_level     = '0;
                        n_out_finished  = 1'b0;
                    end else begin
                        rem_we          = 1'b1;
                        n_slice         = slice_dec;
                        n_out_ran_valid = 1'b1;
                        n_out_id        = r_cur_id;
                        n_out_level     = LEVEL_W'(r_cur_level);
                        n_out_finished  = (rem_next == '0);
                        if (rem_next == '0) begin
                            n_active = 1'b0;
                        end else if (slice_dec == '0) begin
                            n_active  = 1'b0;
                            n_requeue = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slice_mode <= 1'b0;
            r_head       <= '{default: '0};
            r_tail       <= '{default: '0};
            r_count      <= '{default: '0};
            r_cur_id     <= '0;
            r_cur_level  <= '0;
            r_slice      <= '0;
            r_active     <= 1'b0;
            r_requeue    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg.valid) begin
                r_slice_mode <= i_cfg.slice_mode;
            end
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_cur_id    <= n_cur_id;
            r_cur_level <= n_cur_level;
            r_slice     <= n_slice;
            r_active    <= n_active;
            r_requeue   <= n_requeue;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idle          <= n_idle;
        r_out_ran_valid <= n_out_ran_valid;
        r_out_id        <= n_out_id;
        r_out_level     <= n_out_level;
        r_out_finished  <= n_out_finished;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.ran_valid = r_out_ran_valid;
    assign o_res.ran_id    = r_out_id;
    assign o_res.ran_level = r_out_level;
    assign o_res.finished  = r_out_finished;

    mfs_ram #(
        .WIDTH (ID_W),
        .DEPTH (QDEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    mfs_ram #(
        .WIDTH (SVC_W),
        .DEPTH (MAX_PROCS)
    ) u_remain_ram (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (rem_waddr),
        .i_wdata (rem_wdata),
        .i_raddr (rem_raddr),
        .o_rdata (rem_rdata)
    );

endmodule

/* hdl/mfs_checker.sv */
// ============================================================================
// mfs_checker
// Port-level checks of the scheduler, bound to its top level.
// ============================================================================
module mfs_checker #(
    parameter int NUM_LEVELS = mfs_pkg::NUM_LEVELS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_opcode,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_ran_valid,
    input logic [mfs_pkg::ID_W-1:0]    i_ran_id,
    input logic [mfs_pkg::LEVEL_W-1:0] i_ran_level,
    input logic                        i_finished
);
    import mfs_pkg::*;

    // A result word waiting to be taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_ran_valid)
            && $stable(i_ran_id) && $stable(i_ran_level) && $stable(i_finished))
        else $error("result word changed while stalled");

    // An idle tick reports all fields as zero.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ran_valid |-> i_ran_id == '0 && i_ran_level == '0 && !i_finished)
        else $error("idle result with nonzero fields");

    // The reported level is one of the configured levels.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ran_valid |-> int'(i_ran_level) < NUM_LEVELS)
        else $error("result level out of range");

    // A tick occupies the scheduler for at least the following cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_opcode == OP_TICK |=> !i_in_ready)
        else $error("input accepted right after a tick");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

endmodule

bind multilevel_feedback_scheduler mfs_checker #(
    .NUM_LEVELS (NUM_LEVELS)
) u_mfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_opcode (i_item.opcode),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_ran_valid (o_res.ran_valid),
    .i_ran_id    (o_res.ran_id),
    .i_ran_level (o_res.ran_level),
    .i_finished  (o_res.finished)
);
